[sv/b64sc_pkg.sv]
// ----------------------------------------------------------------------------
// b64sc_pkg
// shared types, codes and alphabet functions for the base64 stream codec
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_PAD     = 2'd2;
    localparam logic [1:0] ERR_TRUNC   = 2'd3;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam int         MAX_RESULTS = 4;
    localparam int         CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int         IDX_W       = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic [1:0] err;
    } b64sc_res_t;

    // all results caused by one input beat
    typedef struct packed {
        b64sc_res_t [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]             cnt;
        logic                         eom;
    } b64sc_group_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [5:0] carry;
        logic [1:0] pads;
    } b64sc_state_t;

    typedef struct packed {
        logic       valid;
        logic       pad;
        logic [5:0] val;
    } b64sc_sym_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'h41;
        end else if (v < 6'd52) begin
            return w + 8'h61 - 8'd26;
        end else if (v < 6'd62) begin
            return w + 8'h30 - 8'd52;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    function automatic b64sc_sym_t b64_value(input logic [7:0] c);
        b64sc_sym_t s;
        s = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.valid = 1'b1;
            s.val   = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.valid = 1'b1;
            s.val   = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.valid = 1'b1;
            s.val   = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.valid = 1'b1;
            s.val   = 6'd62;
        end else if (c == 8'h2F) begin
            s.valid = 1'b1;
            s.val   = 6'd63;
        end else if (c == PAD_CHAR) begin
            s.pad   = 1'b1;
        end
        return s;
    endfunction

endpackage

[sv/b64sc_step.sv]
// ----------------------------------------------------------------------------
// b64sc_step
// group state registers and the per-beat encode/decode step
// ----------------------------------------------------------------------------
module b64sc_step
    import b64sc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         mode,
    input  logic [7:0]   byte_in,
    input  logic         eom,
    input  logic         advance,
    output b64sc_group_t group
);

    b64sc_state_t state_reg;
    b64sc_state_t state_next;
    b64sc_state_t st;
    b64sc_sym_t   sym;
    b64sc_res_t   [MAX_RESULTS-1:0] res;
    logic [CNT_W-1:0] n;
    logic [1:0]   enc_phase;

    assign enc_phase = (state_reg.phase == 2'd3) ? 2'd0 : state_reg.phase;
    assign sym       = b64_value(byte_in);

    always_comb begin
        st  = state_reg;
        res = '0;
        n   = '0;
        if (mode == MODE_ENCODE) begin
            case (enc_phase)
                2'd1: begin
                    res[n[IDX_W-1:0]] = '{b64_char({st.carry[1:0], byte_in[7:4]}), 1'b1, ERR_OK};
                    n = n + 1'b1;
                    st.carry = {2'b00, byte_in[3:0]};
                    st.phase = 2'd2;
                end
                2'd2: begin
                    res[n[IDX_W-1:0]] = '{b64_char({st.carry[3:0], byte_in[7:6]}), 1'b1, ERR_OK};
                    n = n + 1'b1;
                    res[n[IDX_W-1:0]] = '{b64_char(byte_in[5:0]), 1'b1, ERR_OK};
                    n = n + 1'b1;
                    st.carry = '0;
                    st.phase = 2'd0;
                end
                default: begin
                    res[n[IDX_W-1:0]] = '{b64_char(byte_in[7:2]), 1'b1, ERR_OK};
                    n = n + 1'b1;
                    st.carry = {4'b0000, byte_in[1:0]};
                    st.phase = 2'd1;
                end
            endcase
            if (eom && st.phase == 2'd1) begin
                res[n[IDX_W-1:0]] = '{b64_char({st.carry[1:0], 4'b0000}), 1'b1, ERR_OK};
                n = n + 1'b1;
                res[n[IDX_W-1:0]] = '{PAD_CHAR, 1'b1, ERR_OK};
                n = n + 1'b1;
                res[n[IDX_W-1:0]] = '{PAD_CHAR, 1'b1, ERR_OK};
                n = n + 1'b1;
            end else if (eom && st.phase == 2'd2) begin
                res[n[IDX_W-1:0]] = '{b64_char({st.carry[3:0], 2'b00}), 1'b1, ERR_OK};
                n = n + 1'b1;
                res[n[IDX_W-1:0]] = '{PAD_CHAR, 1'b1, ERR_OK};
                n = n + 1'b1;
            end
        end else begin
            if (!sym.valid && !sym.pad) begin
                res[n[IDX_W-1:0]] = '{8'h00, 1'b0, ERR_INVALID};
                n = n + 1'b1;
            end else if (sym.pad) begin
                if (st.phase == 2'd2 && st.pads == 2'd0) begin
                    st.pads  = 2'd1;
                    st.phase = 2'd3;
                end else if (st.phase == 2'd3 && st.pads == 2'd0) begin
                    st.pads  = 2'd1;
                    st.phase = 2'd0;
                end else if (st.phase == 2'd3 && st.pads == 2'd1) begin
                    st.pads  = 2'd2;
                    st.phase = 2'd0;
                end else begin
                    res[n[IDX_W-1:0]] = '{8'h00, 1'b0, ERR_PAD};
                    n = n + 1'b1;
                end
            end else if (st.pads != 2'd0) begin
                res[n[IDX_W-1:0]] = '{8'h00, 1'b0, ERR_PAD};
                n = n + 1'b1;
            end else begin
                case (st.phase)
                    2'd0: begin
                        st.carry = sym.val;
                        st.phase = 2'd1;
                    end
                    2'd1: begin
                        res[n[IDX_W-1:0]] = '{{st.carry, sym.val[5:4]}, 1'b1, ERR_OK};
                        n = n + 1'b1;
                        st.carry = {2'b00, sym.val[3:0]};
                        st.phase = 2'd2;
                    end
                    2'd2: begin
                        res[n[IDX_W-1:0]] = '{{st.carry[3:0], sym.val[5:2]}, 1'b1, ERR_OK};
                        n = n + 1'b1;
                        st.carry = {4'b0000, sym.val[1:0]};
                        st.phase = 2'd3;
                    end
                    default: begin
                        res[n[IDX_W-1:0]] = '{{st.carry[1:0], sym.val}, 1'b1, ERR_OK};
                        n = n + 1'b1;
                        st.carry = '0;
                        st.phase = 2'd0;
                    end
                endcase
            end
            if (eom && st.phase != 2'd0) begin
                res[n[IDX_W-1:0]] = '{8'h00, 1'b0, ERR_TRUNC};
                n = n + 1'b1;
            end
        end
        // end of message with nothing to say still yields a marker beat
        if (eom) begin
            if (n == '0) begin
                res[0] = '{8'h00, 1'b0, ERR_OK};
                n = CNT_W'(1);
            end
            st = '0;
        end
        state_next = st;
    end

    assign group.res = res;
    assign group.cnt = n;
    assign group.eom = eom;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/b64sc_emit.sv]
// ----------------------------------------------------------------------------
// b64sc_emit
// holds one result group, hands a beat a cycle to the free output register
// ----------------------------------------------------------------------------
module b64sc_emit
    import b64sc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         grp_valid,
    output logic         grp_ready,
    input  b64sc_group_t grp_in,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_byte_out,
    output logic         m_is_data,
    output logic         m_last_out,
    output logic [1:0]   m_error_code
);

    b64sc_group_t     group_reg;
    logic             group_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             m_valid_reg;
    b64sc_res_t       out_reg;
    logic             last_reg;
    logic             out_free;
    logic             move;
    logic             final_beat;

    assign out_free   = !m_valid_reg || m_ready;
    assign move       = group_valid_reg && out_free;
    assign final_beat = (CNT_W'(idx_reg) == group_reg.cnt - CNT_W'(1));
    assign grp_ready  = !group_valid_reg || (move && final_beat);

    // a group with no results is consumed on the spot and never parked
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_valid_reg <= 1'b0;
            idx_reg         <= '0;
        end else if (grp_valid && grp_ready) begin
            group_valid_reg <= (grp_in.cnt != '0);
            idx_reg         <= '0;
        end else if (move && final_beat) begin
            group_valid_reg <= 1'b0;
        end else if (move) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_valid && grp_ready) begin
            group_reg <= grp_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_reg  <= group_reg.res[idx_reg];
            last_reg <= group_reg.eom && final_beat;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_byte_out   = out_reg.value;
    assign m_is_data    = out_reg.is_data;
    assign m_last_out   = last_reg;
    assign m_error_code = out_reg.err;

endmodule

[sv/base64_stream_codec.sv]
// ----------------------------------------------------------------------------
// base64_stream_codec
// streaming base64 encoder/decoder (standard alphabet, '=' padding)
//
//   channel  | direction | signals                                   | per beat
//   ---------+-----------+-------------------------------------------+-----------------
//   s_       | in        | s_valid s_ready s_byte_in s_end_of_message| one byte or char
//   m_       | out       | m_valid m_ready m_byte_out m_is_data      | one result
//            |           | m_last_out m_error_code                   |
//   apb      | in/out    | psel penable pwrite paddr pwdata prdata   | mode register
//
// an input beat waits in the input register until the group buffer is ready,
// then its whole result group (up to four beats) is built in one pass and parked
// in the group buffer, which drains one result per cycle into the output
// register whenever that register is free (empty or taken by m_ready)
// reset (aresetn low, synchronous) clears mode, group state and all valids
// stalls on m_ready back up through group buffer and input register to s_ready
// ----------------------------------------------------------------------------
module base64_stream_codec
    import b64sc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_end_of_message,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_out,
    output logic        m_is_data,
    output logic        m_last_out,
    output logic [1:0]  m_error_code,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] MODE_ADDR = 2'd0;

    logic         mode_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_eom_reg;
    logic         grp_ready;
    logic         advance;
    b64sc_group_t group;

    // apb: always ready, single mode register at offset 0
    assign pready = 1'b1;
    assign prdata = (paddr == MODE_ADDR) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENCODE;
        end else if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
            mode_reg <= pwdata[0];
        end
    end

    // input register, refills in the same cycle it hands its beat on
    assign advance = in_valid_reg && grp_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
            in_eom_reg  <= s_end_of_message;
        end
    end

    // one-pass step: result group plus next group state
    b64sc_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mode    (mode_reg),
        .byte_in (in_byte_reg),
        .eom     (in_eom_reg),
        .advance (advance),
        .group   (group)
    );

    // group buffer and output register
    b64sc_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .grp_valid    (in_valid_reg),
        .grp_ready    (grp_ready),
        .grp_in       (group),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_out   (m_byte_out),
        .m_is_data    (m_is_data),
        .m_last_out   (m_last_out),
        .m_error_code (m_error_code)
    );

    // marker beats carry no character
    a_marker_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_data |-> m_byte_out == 8'h00)
        else $error("marker beat with nonzero byte");

    // encoder never reports errors
    a_enc_no_err : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && mode_reg == MODE_ENCODE |-> m_error_code == ERR_OK)
        else $error("error code in encode mode");

    // an end-of-message step always yields at least one result
    a_group_nonempty : assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_eom_reg |-> group.cnt != '0)
        else $error("empty result group at end of message");

    // nothing is left pending right after reset
    a_reset_idle : assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("beat pending after reset");

endmodule

[verif/b64_codec_check.sv]
// ----------------------------------------------------------------------------
// b64_codec_check
// watches both channels and the mode register of the base64 codec, predicts
// every result beat from its own copy of the group state and compares
// ----------------------------------------------------------------------------
module b64_codec_check
    import b64sc_pkg::*;
#(
    parameter logic [1:0] MODE_ADDR = 2'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_end_of_message,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_byte_out,
    input  logic        m_is_data,
    input  logic        m_last_out,
    input  logic [1:0]  m_error_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          beats_in,
    output int          beats_out,
    output int          flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [6:0] SYM_PAD    = 7'd64;
    localparam logic [6:0] SYM_BAD    = 7'd65;
    localparam int         SHOW_LIMIT = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       last;
        logic [1:0] err;
    } coded_t;

    coded_t     coded_q[$];
    logic       mode  = MODE_ENCODE;
    logic [1:0] phase = 2'd0;
    logic [5:0] carry = 6'd0;
    logic [1:0] pads  = 2'd0;

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + 8'(v);
        if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
        if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
        return (v == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic logic [6:0] char_code(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
        if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
        if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
        if (c == 8'h2B) return 7'd62;
        if (c == 8'h2F) return 7'd63;
        if (c == PAD_CHAR) return SYM_PAD;
        return SYM_BAD;
    endfunction

    function automatic coded_t data_beat(input logic [7:0] v);
        return '{value: v, is_data: 1'b1, last: 1'b0, err: ERR_OK};
    endfunction

    function automatic coded_t flag_beat(input logic [1:0] e);
        return '{value: 8'h00, is_data: 1'b0, last: 1'b0, err: e};
    endfunction

    // all result beats caused by one input beat, appended to coded_q
    task automatic predict_beat(input logic [7:0] b, input logic eom);
        coded_t     step_q[$];
        coded_t     tail;
        logic [6:0] sym;
        logic [5:0] v;
        if (mode == MODE_DECODE) begin
            sym = char_code(b);
            v   = sym[5:0];
            if (sym == SYM_BAD) begin
                step_q.push_back(flag_beat(ERR_INVALID));
            end else if (sym == SYM_PAD) begin
                if (phase == 2'd2 && pads == 2'd0) begin
                    pads  = 2'd1;
                    phase = 2'd3;
                end else if (phase == 2'd3 && pads == 2'd0) begin
                    pads  = 2'd1;
                    phase = 2'd0;
                end else if (phase == 2'd3 && pads == 2'd1) begin
                    pads  = 2'd2;
                    phase = 2'd0;
                end else begin
                    step_q.push_back(flag_beat(ERR_PAD));
                end
            end else if (pads != 2'd0) begin
                step_q.push_back(flag_beat(ERR_PAD));
            end else begin
                case (phase)
                    2'd0: begin
                        carry = v;
                        phase = 2'd1;
                    end
                    2'd1: begin
                        step_q.push_back(data_beat({carry, v[5:4]}));
                        carry = {2'b00, v[3:0]};
                        phase = 2'd2;
                    end
                    2'd2: begin
                        step_q.push_back(data_beat({carry[3:0], v[5:2]}));
                        carry = {4'b0000, v[1:0]};
                        phase = 2'd3;
                    end
                    default: begin
                        step_q.push_back(data_beat({carry[1:0], v}));
                        carry = 6'd0;
                        phase = 2'd0;
                    end
                endcase
            end
            if (eom && phase != 2'd0) step_q.push_back(flag_beat(ERR_TRUNC));
        end else begin
            case (phase)
                2'd1: begin
                    step_q.push_back(data_beat(alpha_char({carry[1:0], b[7:4]})));
                    carry = {2'b00, b[3:0]};
                    phase = 2'd2;
                end
                2'd2: begin
                    step_q.push_back(data_beat(alpha_char({carry[3:0], b[7:6]})));
                    step_q.push_back(data_beat(alpha_char(b[5:0])));
                    carry = 6'd0;
                    phase = 2'd0;
                end
                default: begin
                    step_q.push_back(data_beat(alpha_char(b[7:2])));
                    carry = {4'b0000, b[1:0]};
                    phase = 2'd1;
                end
            endcase
            if (eom && phase == 2'd1) begin
                step_q.push_back(data_beat(alpha_char({carry[1:0], 4'b0000})));
                step_q.push_back(data_beat(PAD_CHAR));
                step_q.push_back(data_beat(PAD_CHAR));
            end else if (eom && phase == 2'd2) begin
                step_q.push_back(data_beat(alpha_char({carry[3:0], 2'b00})));
                step_q.push_back(data_beat(PAD_CHAR));
            end
        end
        if (eom) begin
            if (step_q.size() == 0) step_q.push_back(flag_beat(ERR_OK));
            tail      = step_q.pop_back();
            tail.last = 1'b1;
            step_q.push_back(tail);
            phase = 2'd0;
            carry = 6'd0;
            pads  = 2'd0;
        end
        foreach (step_q[i]) coded_q.push_back(step_q[i]);
    endtask

    always @(posedge aclk) begin : watch
        coded_t seen;
        coded_t want;
        if (!aresetn) begin
            coded_q.delete();
            mode  = MODE_ENCODE;
            phase = 2'd0;
            carry = 6'd0;
            pads  = 2'd0;
        end else begin
            if (m_valid && m_ready) begin
                seen = '{m_byte_out, m_is_data, m_last_out, m_error_code};
                beats_out++;
                if (seen.err != ERR_OK) flagged++;
                if (coded_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display("%0t: unexpected result byte %02h data %b last %b err %0d",
                                 $time, seen.value, seen.is_data, seen.last, seen.err);
                end else begin
                    want = coded_q.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= SHOW_LIMIT)
                            $display({"%0t: result mismatch, expected byte %02h data %b ",
                                      "last %b err %0d, got byte %02h data %b last %b err %0d"},
                                     $time, want.value, want.is_data, want.last, want.err,
                                     seen.value, seen.is_data, seen.last, seen.err);
                    end
                end
            end
            if (s_valid && s_ready) begin
                beats_in++;
                predict_beat(s_byte_in, s_end_of_message);
            end
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
                mode = pwdata[0];
        end
        pending = coded_q.size();
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives the base64 stream codec with directed and random messages in both
// modes under several idle mixes, the checker predicts and compares results
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b64sc_pkg::*;

    localparam logic [1:0] MODE_ADDR      = 2'd0;
    // input register, group build and a four-beat drain fit well inside this
    localparam int         SETTLE_CYCLES  = 16;
    // cycles with no beat on either channel before the run is given up
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         RANDOM_PER_MIX = 20;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in        = 8'h00;
    logic        s_end_of_message = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [7:0]  m_byte_out;
    logic        m_is_data;
    logic        m_last_out;
    logic [1:0]  m_error_code;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [1:0]  paddr            = 2'd0;
    logic [31:0] pwdata           = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // current idle mix, in percent of cycles
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          idle_cycles = 0;
    logic        cur_mode    = MODE_ENCODE;

    int          fail_count;
    int          pending;
    int          beats_in;
    int          beats_out;
    int          flagged;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    base64_stream_codec DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_in        (s_byte_in),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_out       (m_byte_out),
        .m_is_data        (m_is_data),
        .m_last_out       (m_last_out),
        .m_error_code     (m_error_code),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    b64_codec_check #(
        .MODE_ADDR (MODE_ADDR)
    ) codec_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_in        (s_byte_in),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_out       (m_byte_out),
        .m_is_data        (m_is_data),
        .m_last_out       (m_last_out),
        .m_error_code     (m_error_code),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .fail_count       (fail_count),
        .pending          (pending),
        .beats_in         (beats_in),
        .beats_out        (beats_out),
        .flagged          (flagged)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: counts cycles in which no beat moves on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one input beat, with random idle cycles in front of it per the mix
    task automatic send_beat(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_byte_in        <= b;
        s_end_of_message <= eom;
        do @(posedge aclk); while (!s_ready);
    endtask

    // a run of characters, end of message flagged on the last one if close
    task automatic send_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], close && (i == s.len() - 1));
    endtask

    // hold the sender until every predicted result has come out, then let
    // any result-free beat finish its pass through the block
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mode write on the apb port, only ever with the block idle
    task automatic load_mode(input logic m);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        // upper bits are don't-care for the mode register
        pwdata  <= {31'($urandom()), m};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_mode = m;
    endtask

    initial begin
        logic [7:0] msg[$];
        int         mix_sent;
        int         groups;
        int         tail;
        int         pos;
        logic       close;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // encode out of reset: full group with the '+' and '/' characters
        send_beat(8'hF8, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h3F, 1'b1);
        // one byte left over gives two pads, two bytes give one pad
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'h01, 1'b1);

        load_mode(MODE_DECODE);
        // pad in position 0, invalid char mid-group, pad in position 1,
        // a one-pad close, data after the pad, pad after a closed group
        send_text("=A\200=BC=D=", 1'b1);
        // two pads closing with nonzero leftover bits, eom with no data
        send_text("QR==", 1'b1);
        // a third pad
        send_text("AB===", 1'b1);
        // leave the decoder in position 3 with one pad, then switch mode
        send_text("QR=", 1'b0);
        load_mode(MODE_ENCODE);
        send_beat(8'hA5, 1'b1);
        // leave the encoder holding carry bits, decode on top of them and
        // end on an incomplete group
        send_beat(8'h3F, 1'b0);
        load_mode(MODE_DECODE);
        send_text("z", 1'b1);

        // ---- random part, one block per idle mix ----
        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 68;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 68;
                end
                default: begin
                    idle_pct  = 7;
                    stall_pct = 7;
                end
            endcase
            mix_sent = 0;
            while (mix_sent < RANDOM_PER_MIX) begin
                if ($urandom_range(3) == 0) load_mode(~cur_mode);
                msg.delete();
                if (cur_mode == MODE_ENCODE) begin
                    repeat ($urandom_range(1, 7)) msg.push_back(8'($urandom()));
                end else begin
                    // well-formed text: whole groups plus an optional padded tail
                    groups = $urandom_range(0, 2);
                    tail   = $urandom_range(0, 2);
                    if (tail != 0) tail = tail + 1;
                    if (groups == 0 && tail == 0) tail = 2;
                    repeat (4 * groups + tail) msg.push_back(b64_char(6'($urandom())));
                    if (tail == 2) begin
                        msg.push_back(PAD_CHAR);
                        msg.push_back(PAD_CHAR);
                    end else if (tail == 3) begin
                        msg.push_back(PAD_CHAR);
                    end
                    // some messages get broken: stray byte, stray pad, cut short
                    if ($urandom_range(4) == 0) begin
                        pos = $urandom_range(msg.size() - 1);
                        case ($urandom_range(2))
                            0:       msg[pos] = 8'($urandom());
                            1:       msg.insert(pos, PAD_CHAR);
                            default: void'(msg.pop_back());
                        endcase
                    end
                end
                // a few messages run on into the next one, possibly across a mode switch
                close = ($urandom_range(9) != 0);
                foreach (msg[i]) send_beat(msg[i], close && (i == msg.size() - 1));
                mix_sent += msg.size();
                if ($urandom_range(19) == 0) wait_drained();
            end
        end

        // ---- wrap-up ----
        wait_drained();
        @(negedge aclk);
        if (pending != 0) $display("%0d expected results never arrived", pending);
        $display("covered %0d input beats and %0d result beats (%0d error markers), both modes",
                 beats_in, beats_out, flagged);
        $display("idle mixes run: none, sender 68 pct, receiver 68 pct, both 7 pct");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[base64_stream_codec.f]
sv/b64sc_pkg.sv
sv/b64sc_step.sv
sv/b64sc_emit.sv
sv/base64_stream_codec.sv
verif/b64_codec_check.sv
verif/testbench.sv
